@@ rtl/utf8d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W          = 21;
    localparam int RESULT_DEPTH  = 4;   // result queue entries, power of two, >= 2

    localparam logic [7:0]      CONT_MASK  = 8'hC0;
    localparam logic [7:0]      CONT_TAG   = 8'h80;
    localparam logic [7:0]      LEAD3_MIN  = 8'hE0;
    localparam logic [7:0]      LEAD4_MIN  = 8'hF0;
    localparam logic [7:0]      LEAD_BAD   = 8'hF8;
    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            run_end;
    } t_result;

    // up to two results caused by one byte, slot0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    slot0;
        t_result    slot1;
    } t_pair;

    function automatic t_pair f_push(t_pair p, logic [CP_W-1:0] cp, logic repl);
        t_pair q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.slot0.code_point = cp;
            q.slot0.replaced   = repl;
            q.slot0.run_end    = 1'b0;
        end else begin
            q.slot1.code_point = cp;
            q.slot1.replaced   = repl;
            q.slot1.run_end    = 1'b0;
        end
        q.cnt = p.cnt + 2'd1;
        return q;
    endfunction

endpackage
`default_nettype wire

@@ rtl/utf8d_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_byte_if / utf8d_cp_if
// Valid/ready channels for raw text bytes and decoded code points.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic        run_end;

    modport source (output valid, output code_point, output replaced, output run_end,
                    input ready);
    modport sink   (input valid, input code_point, input replaced, input run_end,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/utf8d_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and per-byte decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module utf8d_core
    import utf8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    output t_pair           o_pair
);

    logic [1:0]      r_exp,  n_exp;
    logic [CP_W-1:0] r_part, n_part;
    logic            r_bad,  n_bad;
    logic            r_disc, n_disc;

    always_comb begin
        t_pair           p;
        logic            is_cont;
        logic            consumed;
        logic [CP_W-1:0] part_sh;

        p        = '0;
        is_cont  = (i_byte & CONT_MASK) == CONT_TAG;
        consumed = 1'b0;
        part_sh  = {r_part[CP_W-7:0], i_byte[5:0]};
        n_exp    = r_exp;
        n_part   = r_part;
        n_bad    = r_bad;
        n_disc   = r_disc;

        if (r_exp != 2'd0) begin
            if (is_cont) begin
                consumed = 1'b1;
                if (r_exp == 2'd1) begin
                    if (r_bad) begin
                        p      = f_push(p, REPL_CP, 1'b1);
                        n_disc = 1'b1;
                    end else begin
                        p = f_push(p, part_sh, 1'b0);
                    end
                    n_exp  = 2'd0;
                    n_part = '0;
                    n_bad  = 1'b0;
                end else begin
                    n_exp  = r_exp - 2'd1;
                    n_part = part_sh;
                end
            end else begin
                // sequence broken: replace it, then decode this byte afresh
                p      = f_push(p, REPL_CP, 1'b1);
                n_exp  = 2'd0;
                n_part = '0;
                n_bad  = 1'b0;
            end
        end

        if (!consumed) begin
            if (!i_byte[7]) begin
                n_disc = 1'b0;
                p      = f_push(p, {13'd0, i_byte}, 1'b0);
            end else if (is_cont) begin
                if (!n_disc) begin
                    p      = f_push(p, REPL_CP, 1'b1);
                    n_disc = 1'b1;
                end
            end else begin
                n_disc = 1'b0;
                if (i_byte < LEAD3_MIN) begin
                    n_exp  = 2'd1;
                    n_part = {16'd0, i_byte[4:0]};
                end else if (i_byte < LEAD4_MIN) begin
                    n_exp  = 2'd2;
                    n_part = {17'd0, i_byte[3:0]};
                end else if (i_byte < LEAD_BAD) begin
                    n_exp  = 2'd3;
                    n_part = {18'd0, i_byte[2:0]};
                end else begin
                    n_exp  = 2'd3;
                    n_part = '0;
                    n_bad  = 1'b1;
                end
            end
        end

        if (i_final) begin
            if (n_exp != 2'd0) begin
                p = f_push(p, REPL_CP, 1'b1);
            end
            n_exp  = 2'd0;
            n_part = '0;
            n_bad  = 1'b0;
            n_disc = 1'b0;
        end

        // mark the last result of this byte
        if (p.cnt == 2'd1) begin
            p.slot0.run_end = 1'b1;
        end
        if (p.cnt == 2'd2) begin
            p.slot1.run_end = 1'b1;
        end
        o_pair = p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_part <= '0;
            r_bad  <= 1'b0;
            r_disc <= 1'b0;
        end else if (i_fire) begin
            r_exp  <= n_exp;
            r_part <= n_part;
            r_bad  <= n_bad;
            r_disc <= n_disc;
        end
    end

endmodule
`default_nettype wire

@@ rtl/utf8d_result_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_result_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module utf8d_result_fifo
    import utf8d_pkg::*;
#(
    parameter int DEPTH = RESULT_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_pair   i_pair,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   wr_ptr_p1;
    logic            pop;
    logic [CW-1:0]   push_cnt;

    assign wr_ptr_p1 = r_wr_ptr + AW'(1);
    assign o_valid   = r_count != '0;
    assign o_head    = r_mem[r_rd_ptr];
    assign pop       = o_valid && i_ready;
    assign o_space   = r_count <= CW'(DEPTH - 2);
    assign push_cnt  = i_push ? CW'(i_pair.cnt) : '0;

    always_ff @(posedge i_clk) begin
        if (i_push && i_pair.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_pair.slot0;
        end
        if (i_push && i_pair.cnt == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_pair.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + push_cnt - CW'(pop);
        end
    end

endmodule
`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result is written into the result queue when the byte that causes it is taken.
// Throughput: one byte per cycle while the queue has room; a byte with two results needs two output
//   transfers, so the result queue (RESULT_DEPTH entries) sets how far input runs ahead.
// Input ready is high while the queue has room for two results.
// Reset: synchronous, active low; clears sequence state and empties the queue.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into 21-bit code points with U+FFFD replacement.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int DEPTH = RESULT_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    utf8d_byte_if.sink  i_in,
    utf8d_cp_if.source  o_out
);

    t_pair   pair;
    t_result head;
    logic    space;
    logic    fire;

    assign i_in.ready = space;
    assign fire       = i_in.valid && space;

    utf8d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in.byte_in),
        .i_final (i_in.final_byte),
        .o_pair  (pair)
    );

    utf8d_result_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_pair  (pair),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    assign o_out.code_point = head.code_point;
    assign o_out.replaced   = head.replaced;
    assign o_out.run_end    = head.run_end;

endmodule
`default_nettype wire
